// ===== rtl/core/mwsf_pkg.sv =====
// Shared types and constants for the mode-window sensor filter.
package mwsf_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int LIMIT_W     = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 2;
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT_LIMIT = 2'd2;

  // Reset values of the configuration registers
  localparam logic signed [SAMPLE_W-1:0] LOW_LIMIT_RST   = -24'sd10240;
  localparam logic signed [SAMPLE_W-1:0] HIGH_LIMIT_RST  = 24'sd32000;
  localparam logic [LIMIT_W-1:0]         FAULT_LIMIT_RST = 8'd10;

  // Classified sample handed from front to back
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       ok;
  } mwsf_item_t;

  // One result beat
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       accepted;
    logic                       fault;
    logic [LIMIT_W-1:0]         fault_count;
  } mwsf_result_t;

endpackage

// ===== rtl/core/mwsf_front.sv =====
// Front end: configuration registers, input handshake and range classification.
module mwsf_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [mwsf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mwsf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mwsf_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [mwsf_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  logic                              q_full,
  output logic                              q_push,
  output mwsf_pkg::mwsf_item_t              q_item,
  output logic [mwsf_pkg::LIMIT_W-1:0]      fault_limit
);
  import mwsf_pkg::*;

  logic signed [SAMPLE_W-1:0] low_limit_r;
  logic signed [SAMPLE_W-1:0] high_limit_r;
  logic [LIMIT_W-1:0]         fault_limit_r;
  logic signed [SAMPLE_W-1:0] sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_limit_r   <= LOW_LIMIT_RST;
      high_limit_r  <= HIGH_LIMIT_RST;
      fault_limit_r <= FAULT_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LOW_LIMIT:   low_limit_r   <= cfg_data[SAMPLE_W-1:0];
        CFG_HIGH_LIMIT:  high_limit_r  <= cfg_data[SAMPLE_W-1:0];
        CFG_FAULT_LIMIT: fault_limit_r <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign sample        = in_tdata[SAMPLE_W-1:0];
  assign in_tready     = !q_full;
  assign q_push        = in_tvalid && in_tready;
  assign q_item.sample = sample;
  assign q_item.ok     = !in_tuser[0] && (sample >= low_limit_r) && (sample <= high_limit_r);
  assign fault_limit   = fault_limit_r;

endmodule

// ===== rtl/core/mwsf_fifo.sv =====
// Short queue of classified samples between front and back.
module mwsf_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mwsf_pkg::mwsf_item_t push_item,
  input  logic                 pop,
  output logic                 full,
  output logic                 not_empty,
  output mwsf_pkg::mwsf_item_t head
);
  import mwsf_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);

  mwsf_item_t      mem_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CNTW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNTW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNTW'(1);
      end
    end
  end

  assign full      = (count_r == CNTW'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !pop) |-> !push)
    else $error("push into a full queue");

endmodule

// ===== rtl/core/mwsf_div.sv =====
// Bit-serial signed-by-unsigned divider, quotient truncated toward zero.
module mwsf_div #(
  parameter int SW = 27,
  parameter int CW = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [SW-1:0] dividend,
  input  logic [CW-1:0]        divisor,
  output logic                 done,
  output logic signed [SW-1:0] quotient
);

  localparam int STW = $clog2(SW + 1);

  logic [SW-1:0]  q_r;
  logic [CW-1:0]  rem_r;
  logic [CW-1:0]  div_r;
  logic           neg_r;
  logic           busy_r;
  logic           done_r;
  logic [STW-1:0] step_r;
  logic [CW:0]    rem_sh;
  logic           fits;

  assign rem_sh = {rem_r, q_r[SW-1]};
  assign fits   = (rem_sh >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[SW-1];
      q_r   <= dividend[SW-1] ? (~dividend + SW'(1)) : dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[SW-2:0], fits};
      rem_r <= fits ? CW'(rem_sh - {1'b0, div_r}) : rem_sh[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STW'(SW);
      end else if (busy_r) begin
        step_r <= step_r - STW'(1);
        if (step_r == STW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

// ===== rtl/core/mwsf_back.sv =====
// Back end: fault counting, sample window, mode search, mean and result register.
module mwsf_back #(
  parameter int WINDOW_LEN = 5,
  parameter int FRAC_BITS  = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  mwsf_pkg::mwsf_item_t          q_item,
  output logic                          q_pop,
  input  logic [mwsf_pkg::LIMIT_W-1:0]  fault_limit,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output mwsf_pkg::mwsf_result_t        out_res
);
  import mwsf_pkg::*;

  localparam int IW = $clog2(WINDOW_LEN);
  localparam int CW = $clog2(WINDOW_LEN + 1);
  localparam int SW = SAMPLE_W + CW;
  localparam int RW = SAMPLE_W + 2;
  localparam int DW = SAMPLE_W + 3;
  localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW_LEN - 1);
  localparam logic signed [DW-1:0] ONE_UNIT = DW'(1) << FRAC_BITS;
  localparam logic signed [DW-1:0] HALF_UNIT = ONE_UNIT >>> 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MODE = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  // Round to whole units, halves away from zero.
  function automatic logic signed [RW-1:0] round_units(input logic signed [SAMPLE_W-1:0] v);
    logic signed [RW-1:0] vx;
    logic [RW-1:0]        mag;
    logic [RW-1:0]        sh;
    vx  = RW'(v);
    mag = ((vx < 0) ? -vx : vx) + RW'(HALF_UNIT);
    sh  = mag >> FRAC_BITS;
    return (vx < 0) ? -$signed(sh) : $signed(sh);
  endfunction

  logic [2:0]                 state_r;
  logic signed [SAMPLE_W-1:0] win_r [WINDOW_LEN];
  logic                       primed_r;
  logic [LIMIT_W-1:0]         reject_r;
  logic                       fault_r;
  logic                       accepted_r;
  logic signed [SAMPLE_W-1:0] last_filtered_r;
  logic [IW-1:0]              idx_r;
  logic [CW-1:0]              best_r;
  logic signed [RW-1:0]       mode_r;
  logic signed [SW-1:0]       sum_r;
  logic [CW-1:0]              cnt_r;
  logic                       out_valid_r;
  mwsf_result_t               out_res_r;

  logic signed [RW-1:0]       rnd [WINDOW_LEN];
  logic [CW-1:0]              match_cnt;
  logic signed [DW-1:0]       mode_fx;
  logic signed [DW-1:0]       delta;
  logic signed [DW-1:0]       abs_delta;
  logic                       near;
  logic signed [SW-1:0]       sum_nxt;
  logic [CW-1:0]              cnt_nxt;
  logic                       div_start;
  logic                       div_done;
  logic signed [SW-1:0]       quotient;
  logic                       emit_go;

  always_comb begin
    for (int k = 0; k < WINDOW_LEN; k++) begin
      rnd[k] = round_units(win_r[k]);
    end
  end

  always_comb begin
    match_cnt = '0;
    for (int k = 0; k < WINDOW_LEN; k++) begin
      if (rnd[k] == rnd[idx_r]) begin
        match_cnt = match_cnt + CW'(1);
      end
    end
  end

  assign mode_fx   = DW'(mode_r) <<< FRAC_BITS;
  assign delta     = mode_fx - DW'(win_r[idx_r]);
  assign abs_delta = (delta < 0) ? -delta : delta;
  assign near      = (abs_delta < ONE_UNIT);
  assign sum_nxt   = near ? (sum_r + SW'(win_r[idx_r])) : sum_r;
  assign cnt_nxt   = near ? (cnt_r + CW'(1)) : cnt_r;

  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign div_start = (state_r == ST_SUM) && (idx_r == LAST_IDX);
  assign emit_go   = (state_r == ST_EMIT) && (!out_valid_r || out_tready);

  mwsf_div #(
    .SW(SW),
    .CW(CW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(sum_nxt),
    .divisor (cnt_nxt),
    .done    (div_done),
    .quotient(quotient)
  );

  // Window shift; the first accepted sample fills every entry.
  always_ff @(posedge clk) begin
    if (q_pop && q_item.ok) begin
      win_r[0] <= q_item.sample;
      for (int k = 1; k < WINDOW_LEN; k++) begin
        win_r[k] <= primed_r ? win_r[k-1] : q_item.sample;
      end
    end
  end

  // Datapath registers of the mode and mean passes
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        idx_r  <= '0;
        best_r <= '0;
        mode_r <= '0;
        sum_r  <= '0;
        cnt_r  <= '0;
      end
      ST_MODE: begin
        if (match_cnt > best_r) begin
          best_r <= match_cnt;
          mode_r <= rnd[idx_r];
        end
        idx_r <= (idx_r == LAST_IDX) ? '0 : idx_r + IW'(1);
      end
      ST_SUM: begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
        idx_r <= idx_r + IW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      primed_r        <= 1'b0;
      reject_r        <= '0;
      fault_r         <= 1'b0;
      accepted_r      <= 1'b0;
      last_filtered_r <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            accepted_r <= q_item.ok;
            if (q_item.ok) begin
              primed_r <= 1'b1;
              reject_r <= '0;
              fault_r  <= 1'b0;
              state_r  <= ST_MODE;
            end else begin
              if (reject_r >= fault_limit) begin
                fault_r <= 1'b1;
              end else begin
                reject_r <= reject_r + LIMIT_W'(1);
              end
              state_r <= ST_EMIT;
            end
          end
        end
        ST_MODE: begin
          if (idx_r == LAST_IDX) begin
            state_r <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (idx_r == LAST_IDX) begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            last_filtered_r <= quotient[SAMPLE_W-1:0];
            state_r         <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_res_r.filtered    <= last_filtered_r;
      out_res_r.accepted    <= accepted_r;
      out_res_r.fault       <= fault_r;
      out_res_r.fault_count <= reject_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_res    = out_res_r;

  a_accept_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res.accepted) |-> (!out_res.fault && out_res.fault_count == '0))
    else $error("accepted result carries fault state");

  a_reject_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !q_item.ok && reject_r < fault_limit)
      |=> (reject_r == $past(reject_r) + LIMIT_W'(1)))
    else $error("reject counter did not advance");

  a_mean_count: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (cnt_nxt != '0))
    else $error("mean started with empty selection");

endmodule

// ===== rtl/core/mode_window_sensor_filter.sv =====
// Top level of the mode-window sensor filter: front end, queue and back end.
//
// One input beat carries a Q.FRAC_BITS sample and an invalid flag; every input
// beat yields exactly one result beat. A sample that is flagged invalid or lies
// outside [low_limit, high_limit] is rejected: the consecutive-reject counter
// advances up to fault_limit, and a rejection with the counter already at the
// limit raises the fault flag; the last filtered value is repeated. An accepted
// sample clears counter and flag, enters a WINDOW_LEN-deep window (the first
// one fills it), and the result is the truncated mean of the entries within
// 1.0 of the window's mode (whole-unit rounding, halves away from zero, ties to
// the newest entry). Timing: the front end classifies in the accept cycle and
// parks samples in a two-entry queue, so in_tready only drops when the queue is
// full. The back end handles one sample at a time: a rejected sample goes
// straight to the emit state, an accepted one runs the one-entry-per-cycle mode
// and mean passes and then the bit-serial divider. The result sits in an
// output register, so the back end moves on while a beat waits for out_tready.
// Configuration must be written only while the block is idle; the block itself
// does not enforce this. Index 3 is ignored.
module mode_window_sensor_filter #(
  parameter int WINDOW_LEN = 5,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic [mwsf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mwsf_pkg::CFG_DATA_W-1:0]     cfg_data,
  // sample stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mwsf_pkg::IN_TDATA_W-1:0]     in_tdata,   // [23:0] sample
  input  logic [mwsf_pkg::IN_TUSER_W-1:0]     in_tuser,   // [0] sample_invalid
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mwsf_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [23:0] filtered, [31:24] fault_count
  output logic [mwsf_pkg::OUT_TUSER_W-1:0]    out_tuser   // [0] accepted, [1] fault
);
  import mwsf_pkg::*;

  logic               q_full;
  logic               q_push;
  logic               q_pop;
  logic               q_not_empty;
  mwsf_item_t         push_item;
  mwsf_item_t         head_item;
  logic [LIMIT_W-1:0] fault_limit;
  mwsf_result_t       res;

  // Front: hold config, classify each beat and push it into the queue
  mwsf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (push_item),
    .fault_limit(fault_limit)
  );

  // Queue: decouple classification from the slow filter pass
  mwsf_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(push_item),
    .pop      (q_pop),
    .full     (q_full),
    .not_empty(q_not_empty),
    .head     (head_item)
  );

  // Back: advance fault state, filter and drive the result register
  mwsf_back #(
    .WINDOW_LEN(WINDOW_LEN),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_not_empty),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .fault_limit(fault_limit),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {res.fault_count, res.filtered};
  assign out_tuser = {res.fault, res.accepted};

endmodule
